[rtl/tsb_pkg.sv]
// Package for the timer slot bank: sizes, action and error codes, cell types.
// Used by the interfaces, the cell, the interval converter and the top level.
package tsb_pkg;

    localparam int GENERAL_SLOTS     = 16;
    localparam int ALL_SLOTS         = GENERAL_SLOTS + 1;
    localparam int RESV_SLOT         = GENERAL_SLOTS;
    localparam int TICK_MS_DEF       = 10;
    localparam int COUNT_WIDTH_DEF   = 32;

    localparam int ACTION_W   = 3;
    localparam int MS_W       = 32;
    localparam int ID_W       = 5;
    localparam int ERR_W      = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK        = 3'd0,
        ACT_REG         = 3'd1,
        ACT_UNREG       = 3'd2,
        ACT_RESV_REG    = 3'd3,
        ACT_RESV_UNREG  = 3'd4,
        ACT_READ_FLAG   = 3'd5
    } t_action;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK     = 2'd0,
        ERR_FULL   = 2'd1,
        ERR_BAD_ID = 2'd2
    } t_err;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_TICK,
        OP_ARM,
        OP_FREE,
        OP_READ
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     handler;
        logic     loop;
    } t_cell_cmd;

    typedef struct packed {
        logic en_nxt;
        logic flag;
        logic expired;
        logic claim;
    } t_cell_stat;

endpackage

[rtl/tsb_if.sv]
// Handshake interfaces for the input and result channels of the timer slot bank.
// Depends on tsb_pkg for the field widths.
interface tsb_in_if;
    logic                        valid;
    logic                        ready;
    logic [tsb_pkg::ACTION_W-1:0] action;
    logic [tsb_pkg::MS_W-1:0]    interval_ms;
    logic                        has_handler;
    logic                        loop_mode;
    logic [tsb_pkg::ID_W-1:0]    slot_id;

    modport source (output valid, action, interval_ms, has_handler, loop_mode, slot_id,
                    input ready);
    modport sink   (input valid, action, interval_ms, has_handler, loop_mode, slot_id,
                    output ready);
endinterface

interface tsb_out_if;
    logic                             valid;
    logic                             ready;
    logic [tsb_pkg::ID_W-1:0]         assigned_id;
    logic [tsb_pkg::ERR_W-1:0]        error_code;
    logic                             flag_value;
    logic [tsb_pkg::ALL_SLOTS-1:0]    expired_mask;
    logic [tsb_pkg::GENERAL_SLOTS-1:0] occupied_mask;

    modport source (output valid, assigned_id, error_code, flag_value, expired_mask,
                    occupied_mask, input ready);
    modport sink   (input valid, assigned_id, error_code, flag_value, expired_mask,
                    occupied_mask, output ready);
endinterface

[rtl/tsb_cell.sv]
// One timer slot: enable, mode bits, flag, period and down counter.
// Passes the free-slot search token to its neighbor. Depends on tsb_pkg.
module tsb_cell #(
    parameter int COUNT_WIDTH = tsb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tsb_pkg::t_cell_cmd     i_cmd,
    input  logic                   i_sel,
    input  logic                   i_claim,
    input  logic [COUNT_WIDTH-1:0] i_ticks,
    output tsb_pkg::t_cell_stat    o_stat
);
    import tsb_pkg::*;

    logic                   r_en;
    logic                   r_flag;
    logic                   r_loop;
    logic                   r_handler;
    logic [COUNT_WIDTH-1:0] r_period;
    logic [COUNT_WIDTH-1:0] r_cnt;
    logic [COUNT_WIDTH-1:0] cnt_dec;
    logic                   hit;
    logic                   arm;

    always_comb begin
        cnt_dec = (r_cnt != '0 && !r_flag) ? r_cnt - COUNT_WIDTH'(1) : r_cnt;
        hit     = (cnt_dec == '0);
        arm     = (i_cmd.op == OP_ARM) && i_claim && !r_en;
    end

    always_comb begin
        o_stat.claim   = i_claim && r_en;
        o_stat.flag    = r_flag;
        o_stat.expired = (i_cmd.op == OP_TICK) && r_en && hit && r_handler;
        unique case (i_cmd.op)
            OP_TICK: o_stat.en_nxt = r_en && !(hit && !r_loop);
            OP_ARM:  o_stat.en_nxt = r_en || arm;
            OP_FREE: o_stat.en_nxt = r_en && !i_sel;
            default: o_stat.en_nxt = r_en;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en      <= 1'b0;
            r_flag    <= 1'b0;
            r_loop    <= 1'b0;
            r_handler <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_TICK: begin
                    if (r_en && hit) begin
                        if (!r_handler) begin
                            r_flag <= 1'b1;
                        end
                        if (!r_loop) begin
                            r_en <= 1'b0;
                        end
                    end
                end
                OP_ARM: begin
                    if (arm) begin
                        r_en      <= 1'b1;
                        r_flag    <= 1'b0;
                        r_loop    <= i_cmd.loop;
                        r_handler <= i_cmd.handler;
                    end
                end
                OP_FREE: begin
                    if (i_sel) begin
                        r_en <= 1'b0;
                    end
                end
                OP_READ: begin
                    if (i_sel && r_flag && r_loop) begin
                        r_flag <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (arm) begin
            r_period <= i_ticks;
            r_cnt    <= i_ticks;
        end else if (i_cmd.op == OP_TICK && r_en) begin
            r_cnt <= (hit && r_loop) ? r_period : cnt_dec;
        end
    end

endmodule

[rtl/tsb_div.sv]
// Interval converter: ceiling of milliseconds over the tick length, saturated
// to the counter width, by a reciprocal multiply split into low and high halves. Depends on tsb_pkg.
module tsb_div #(
    parameter int TICK_MS     = tsb_pkg::TICK_MS_DEF,
    parameter int COUNT_WIDTH = tsb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tsb_pkg::MS_W-1:0]  i_ms,
    output logic                      o_done,
    output logic [COUNT_WIDTH-1:0]    o_ticks
);
    import tsb_pkg::*;

    localparam int RECIP_SH = MS_W + $clog2(TICK_MS);
    localparam int RECIP_W  = MS_W + 1;
    localparam int LO_W     = 17;
    localparam int HI_W     = RECIP_W - LO_W;
    localparam int PROD_W   = RECIP_SH + MS_W + 1;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SH) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_FULL);
    localparam logic [LO_W-1:0]    RECIP_LO = RECIP[LO_W-1:0];
    localparam logic [HI_W-1:0]    RECIP_HI = RECIP[RECIP_W-1:LO_W];
    localparam logic [MS_W-1:0]    DIVISOR  = MS_W'(TICK_MS);

    typedef enum logic [2:0] {
        D_IDLE,
        D_LO,
        D_HI,
        D_REM,
        D_FIN
    } t_dstate;

    t_dstate                 r_state;
    logic [MS_W-1:0]         r_ms;
    logic [MS_W+LO_W-1:0]    r_plo;
    logic [MS_W-1:0]         r_quo;
    logic                    r_inc;
    logic [MS_W+HI_W-1:0]    prod_hi;
    logic [PROD_W-1:0]       prod;
    logic [MS_W:0]           sum;

    always_comb begin
        prod_hi = (MS_W + HI_W)'(r_ms) * (MS_W + HI_W)'(RECIP_HI);
        prod    = (PROD_W'(prod_hi) << LO_W) + PROD_W'(r_plo);
        sum     = {1'b0, r_quo} + (MS_W + 1)'(r_inc);
        if (sum[MS_W:COUNT_WIDTH] != '0) begin
            o_ticks = '1;
        end else begin
            o_ticks = sum[COUNT_WIDTH-1:0];
        end
        o_done = (r_state == D_FIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_state <= D_LO;
                        r_ms    <= i_ms;
                    end
                end
                D_LO: begin
                    r_plo   <= (MS_W + LO_W)'(r_ms) * (MS_W + LO_W)'(RECIP_LO);
                    r_state <= D_HI;
                end
                D_HI: begin
                    r_quo   <= prod[RECIP_SH +: MS_W];
                    r_state <= D_REM;
                end
                D_REM: begin
                    r_inc   <= (r_quo * DIVISOR != r_ms);
                    r_state <= D_FIN;
                end
                D_FIN: begin
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/timer_slot_bank.sv]
// Timer slot bank top level: input decode, output register, interval converter
// and the row of slot cells. Depends on tsb_pkg, tsb_if, tsb_cell and tsb_div.
//
//   channel | direction | carries
//   i_in    | sink      | action, interval_ms, has_handler, loop_mode, slot_id
//   o_out   | source    | assigned_id, error_code, flag_value, expired_mask, occupied_mask
//
// Tick, unregister and flag read results are registered when the transaction is accepted.
// Register transactions wait for the three steps of the interval converter.
// Reset is synchronous; all slots come out of reset free with clear flags.
// A new transaction is taken once the previous result has left or is leaving.
module timer_slot_bank #(
    parameter int TICK_MS     = tsb_pkg::TICK_MS_DEF,
    parameter int COUNT_WIDTH = tsb_pkg::COUNT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsb_in_if.sink     i_in,
    tsb_out_if.source  o_out
);
    import tsb_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

    t_state                    r_state;
    t_action                   r_act;
    logic                      r_handler;
    logic                      r_loop;
    logic                      r_out_valid;
    logic [ID_W-1:0]           r_assigned;
    t_err                      r_err;
    logic                      r_flag;
    logic [ALL_SLOTS-1:0]      r_expired;
    logic [GENERAL_SLOTS-1:0]  r_occ;

    logic                      accept;
    logic                      div_start;
    logic                      div_done;
    logic [COUNT_WIDTH-1:0]    ticks;
    t_cell_cmd                 cmd;
    logic [ALL_SLOTS-1:0]      id_match;
    logic [ALL_SLOTS-1:0]      sel;
    logic [ALL_SLOTS-1:0]      claim_in;
    t_cell_stat                stat [ALL_SLOTS];
    logic [ALL_SLOTS-1:0]      en_nxt;
    logic [ALL_SLOTS-1:0]      flags;
    logic [ALL_SLOTS-1:0]      expired;
    logic [ALL_SLOTS-1:0]      armed;
    logic                      id_zero;
    logic                      id_big;
    logic [ID_W-1:0]           arm_id;
    t_err                      arm_err;
    t_err                      now_err;
    logic                      now_flag;

    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;
    assign div_start  = accept && (i_in.action == ACT_REG || i_in.action == ACT_RESV_REG);

    assign o_out.valid         = r_out_valid;
    assign o_out.assigned_id   = r_assigned;
    assign o_out.error_code    = r_err;
    assign o_out.flag_value    = r_flag;
    assign o_out.expired_mask  = r_expired;
    assign o_out.occupied_mask = r_occ;

    tsb_div #(
        .TICK_MS     (TICK_MS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_ms    (i_in.interval_ms),
        .o_done  (div_done),
        .o_ticks (ticks)
    );

    always_comb begin
        id_zero = (i_in.slot_id == '0);
        id_big  = (i_in.slot_id > ID_W'(ALL_SLOTS));
        for (int i = 0; i < ALL_SLOTS; i++) begin
            id_match[i] = (i_in.slot_id == ID_W'(i + 1));
        end
    end

    always_comb begin
        cmd.handler = r_handler;
        cmd.loop    = r_loop;
        cmd.op      = OP_NOP;
        sel         = '0;
        if (r_state == S_DIV && div_done) begin
            cmd.op = OP_ARM;
        end else if (accept) begin
            unique case (i_in.action)
                ACT_TICK: begin
                    cmd.op = OP_TICK;
                end
                ACT_UNREG: begin
                    cmd.op = OP_FREE;
                    sel    = id_match;
                end
                ACT_RESV_UNREG: begin
                    cmd.op         = OP_FREE;
                    sel[RESV_SLOT] = id_match[RESV_SLOT];
                end
                ACT_READ_FLAG: begin
                    cmd.op = OP_READ;
                    sel    = id_match;
                end
                default: begin
                end
            endcase
        end
    end

    assign claim_in[0]         = (r_act == ACT_REG);
    assign claim_in[RESV_SLOT] = (r_act == ACT_RESV_REG);

    for (genvar g = 0; g < ALL_SLOTS; g++) begin : g_cell
        if (g > 0 && g < RESV_SLOT) begin : g_link
            assign claim_in[g] = stat[g-1].claim;
        end
        tsb_cell #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_sel   (sel[g]),
            .i_claim (claim_in[g]),
            .i_ticks (ticks),
            .o_stat  (stat[g])
        );
        assign en_nxt[g]  = stat[g].en_nxt;
        assign flags[g]   = stat[g].flag;
        assign expired[g] = stat[g].expired;
        assign armed[g]   = claim_in[g] && !stat[g].claim;
    end

    always_comb begin
        arm_id = '0;
        for (int i = 0; i < ALL_SLOTS; i++) begin
            if (armed[i]) begin
                arm_id = arm_id | ID_W'(i + 1);
            end
        end
        arm_err = (armed == '0) ? ERR_FULL : ERR_OK;
    end

    always_comb begin
        now_err  = ERR_OK;
        now_flag = 1'b0;
        unique case (i_in.action)
            ACT_UNREG: begin
                if (!id_zero && id_big) begin
                    now_err = ERR_BAD_ID;
                end
            end
            ACT_RESV_UNREG: begin
                if (!id_zero && !id_match[RESV_SLOT]) begin
                    now_err = ERR_BAD_ID;
                end
            end
            ACT_READ_FLAG: begin
                if (!id_zero && id_big) begin
                    now_err = ERR_BAD_ID;
                end
                now_flag = |(id_match & flags);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_act       <= ACT_TICK;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (div_start) begin
                        r_state     <= S_DIV;
                        r_act       <= t_action'(i_in.action);
                        r_handler   <= i_in.has_handler;
                        r_loop      <= i_in.loop_mode;
                        r_out_valid <= 1'b0;
                    end else if (accept) begin
                        r_out_valid <= 1'b1;
                        r_assigned  <= '0;
                        r_err       <= now_err;
                        r_flag      <= now_flag;
                        r_expired   <= expired;
                        r_occ       <= en_nxt[GENERAL_SLOTS-1:0];
                    end else if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state     <= S_IDLE;
                        r_act       <= ACT_TICK;
                        r_out_valid <= 1'b1;
                        r_assigned  <= arm_id;
                        r_err       <= arm_err;
                        r_flag      <= 1'b0;
                        r_expired   <= '0;
                        r_occ       <= en_nxt[GENERAL_SLOTS-1:0];
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for timer_slot_bank: directed and random transactions checked against a predictor.
// Depends on tsb_pkg, the tsb_in_if and tsb_out_if interfaces and the timer_slot_bank RTL.
module tb_top;
    import tsb_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 50;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [MS_W-1:0]     interval_ms;
        logic                has_handler;
        logic                loop_mode;
        logic [ID_W-1:0]     slot_id;
    } t_timer_req;

    typedef struct packed {
        logic [ID_W-1:0]          assigned_id;
        t_err                     error_code;
        logic                     flag_value;
        logic [ALL_SLOTS-1:0]     expired_mask;
        logic [GENERAL_SLOTS-1:0] occupied_mask;
    } t_bank_result;

    logic i_clk;
    logic i_rst_n;

    tsb_in_if  in_ch ();
    tsb_out_if out_ch ();

    timer_slot_bank dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic                       slot_on      [ALL_SLOTS];
    logic                       slot_repeat  [ALL_SLOTS];
    logic                       slot_evt     [ALL_SLOTS];
    logic                       slot_flagged [ALL_SLOTS];
    logic [COUNT_WIDTH_DEF-1:0] slot_reload  [ALL_SLOTS];
    logic [COUNT_WIDTH_DEF-1:0] slot_left    [ALL_SLOTS];
    logic [GENERAL_SLOTS-1:0]   occ_bits;

    t_bank_result pending_results[$];
    int  mismatches = 0;
    int  cycle_count = 0;
    bit  calm;
    bit  hold_req;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void arm_slot(int s, t_timer_req rq);
        longint unsigned ticks;
        longint unsigned lim;
        lim = (64'd1 << COUNT_WIDTH_DEF) - 1;
        ticks = rq.interval_ms / TICK_MS_DEF;
        if (rq.interval_ms % TICK_MS_DEF != 0)
            ticks++;
        if (ticks > lim)
            ticks = lim;
        slot_reload[s]  = ticks[COUNT_WIDTH_DEF-1:0];
        slot_left[s]    = ticks[COUNT_WIDTH_DEF-1:0];
        slot_evt[s]     = rq.has_handler;
        slot_repeat[s]  = rq.loop_mode;
        slot_flagged[s] = 1'b0;
        slot_on[s]      = 1'b1;
        if (s < GENERAL_SLOTS)
            occ_bits[s] = 1'b1;
    endfunction

    function automatic void free_slot(int s);
        slot_on[s] = 1'b0;
        if (s < GENERAL_SLOTS)
            occ_bits[s] = 1'b0;
    endfunction

    function automatic t_bank_result predict_bank_step(t_timer_req rq);
        t_bank_result r;
        int s;
        int id;
        bit found;
        r = '0;
        id = rq.slot_id;
        case (rq.action)
            ACT_TICK: begin
                for (s = 0; s < ALL_SLOTS; s++) begin
                    if (slot_on[s]) begin
                        if (slot_left[s] != 0 && !slot_flagged[s])
                            slot_left[s] = slot_left[s] - 1;
                        if (slot_left[s] == 0) begin
                            if (slot_evt[s])
                                r.expired_mask[s] = 1'b1;
                            else
                                slot_flagged[s] = 1'b1;
                            if (slot_repeat[s])
                                slot_left[s] = slot_reload[s];
                            else
                                free_slot(s);
                        end
                    end
                end
            end
            ACT_REG: begin
                found = 1'b0;
                r.error_code = ERR_FULL;
                for (s = 0; s < GENERAL_SLOTS; s++) begin
                    if (!found && !slot_on[s]) begin
                        found = 1'b1;
                        arm_slot(s, rq);
                        r.assigned_id = ID_W'(s + 1);
                        r.error_code = ERR_OK;
                    end
                end
            end
            ACT_UNREG: begin
                if (id > ALL_SLOTS)
                    r.error_code = ERR_BAD_ID;
                else if (id != 0)
                    free_slot(id - 1);
            end
            ACT_RESV_REG: begin
                if (slot_on[RESV_SLOT]) begin
                    r.error_code = ERR_FULL;
                end else begin
                    arm_slot(RESV_SLOT, rq);
                    r.assigned_id = ID_W'(RESV_SLOT + 1);
                end
            end
            ACT_RESV_UNREG: begin
                if (id == RESV_SLOT + 1)
                    free_slot(RESV_SLOT);
                else if (id != 0)
                    r.error_code = ERR_BAD_ID;
            end
            ACT_READ_FLAG: begin
                if (id > ALL_SLOTS) begin
                    r.error_code = ERR_BAD_ID;
                end else if (id != 0) begin
                    r.flag_value = slot_flagged[id - 1];
                    if (slot_flagged[id - 1] && slot_repeat[id - 1])
                        slot_flagged[id - 1] = 1'b0;
                end
            end
            default: ;
        endcase
        r.occupied_mask = occ_bits;
        return r;
    endfunction

    task automatic report_error(string what, longint unsigned got, longint unsigned want);
        $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Predictions are queued before results are checked at each rising edge, so
    // an expectation is in the queue before its result can be checked.
    always @(posedge i_clk) begin
        t_timer_req rq;
        t_bank_result want;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            rq.action      = in_ch.action;
            rq.interval_ms = in_ch.interval_ms;
            rq.has_handler = in_ch.has_handler;
            rq.loop_mode   = in_ch.loop_mode;
            rq.slot_id     = in_ch.slot_id;
            pending_results.push_back(predict_bank_step(rq));
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_error("unexpected result", out_ch.occupied_mask, 0);
            end else begin
                want = pending_results.pop_front();
                if (out_ch.assigned_id !== want.assigned_id)
                    report_error("assigned_id", out_ch.assigned_id, want.assigned_id);
                if (out_ch.error_code !== want.error_code)
                    report_error("error_code", out_ch.error_code, want.error_code);
                if (out_ch.flag_value !== want.flag_value)
                    report_error("flag_value", out_ch.flag_value, want.flag_value);
                if (out_ch.expired_mask !== want.expired_mask)
                    report_error("expired_mask", out_ch.expired_mask, want.expired_mask);
                if (out_ch.occupied_mask !== want.occupied_mask)
                    report_error("occupied_mask", out_ch.occupied_mask, want.occupied_mask);
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        int n;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready = 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(negedge i_clk);
                hold_req = 1'b0;
                out_ch.ready = 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
                out_ch.ready = 1'b1;
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // Entered and left at a falling edge; valid stays high between transactions unless a random idle gap is inserted.
    task automatic send_item(logic [ACTION_W-1:0] act, logic [MS_W-1:0] ms, logic hh,
                             logic lp, logic [ID_W-1:0] id);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.action      = act;
        in_ch.interval_ms = ms;
        in_ch.has_handler = hh;
        in_ch.loop_mode   = lp;
        in_ch.slot_id     = id;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [ID_W-1:0] rand_slot_id();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 7)
            return '0;
        else if (pick < 15)
            return ID_W'($urandom_range(ALL_SLOTS + 1, 31));
        return ID_W'($urandom_range(1, ALL_SLOTS));
    endfunction

    function automatic logic [MS_W-1:0] rand_interval();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return $urandom;
        else if (pick == 1)
            return '1;
        return MS_W'($urandom_range(0, 60));
    endfunction

    task automatic test_spare_and_empty();
        send_item(ACT_SPARE_LO, $urandom, 1'b1, 1'b1, 5'd3);
        send_item(ACT_SPARE_HI, $urandom, 1'b0, 1'b0, 5'd31);
        send_item(ACT_READ_FLAG, $urandom, 1'b1, 1'b0, 5'd0);
    endtask

    task automatic test_bank_full();
        int i;
        logic [MS_W-1:0] ms;
        for (i = 0; i < GENERAL_SLOTS; i++) begin
            if (i == 0)
                ms = '0;
            else if (i == 1)
                ms = '1;
            else
                ms = MS_W'(i * 7);
            send_item(ACT_REG, ms, i[0], i[1], ID_W'($urandom));
        end
        send_item(ACT_REG, 32'd50, 1'b0, 1'b0, 5'd0);
        send_item(ACT_RESV_REG, 32'd25, 1'b0, 1'b1, 5'd0);
        send_item(ACT_RESV_REG, 32'd30, 1'b1, 1'b0, 5'd0);
    endtask

    task automatic test_bad_ids();
        send_item(ACT_UNREG, $urandom, 1'b0, 1'b1, 5'd31);
        send_item(ACT_UNREG, $urandom, 1'b1, 1'b0, 5'd17);
        send_item(ACT_RESV_UNREG, $urandom, 1'b0, 1'b0, 5'd5);
        send_item(ACT_RESV_UNREG, $urandom, 1'b1, 1'b1, 5'd0);
        send_item(ACT_READ_FLAG, $urandom, 1'b0, 1'b0, 5'd18);
    endtask

    task automatic test_flag_rearm();
        send_item(ACT_TICK, $urandom, 1'b1, 1'b0, 5'd0);
        send_item(ACT_TICK, $urandom, 1'b0, 1'b1, 5'd9);
        send_item(ACT_READ_FLAG, $urandom, 1'b0, 1'b0, 5'd3);
    endtask

    task automatic test_output_backpressure();
        int i;
        hold_req = 1'b1;
        for (i = 0; i < 8; i++)
            send_item(i[0] ? ACT_READ_FLAG : ACT_TICK, $urandom, i[1], i[2], rand_slot_id());
        wait_results_drained();
    endtask

    task automatic test_random_traffic(int count);
        int i;
        int pick;
        logic [ACTION_W-1:0] act;
        logic [ID_W-1:0] id;
        logic [MS_W-1:0] ms;
        for (i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            ms = $urandom;
            id = rand_slot_id();
            if (pick < 40) begin
                act = ACT_TICK;
            end else if (pick < 60) begin
                act = ACT_REG;
                ms = rand_interval();
            end else if (pick < 70) begin
                act = ACT_UNREG;
            end else if (pick < 75) begin
                act = ACT_RESV_REG;
                ms = rand_interval();
            end else if (pick < 80) begin
                act = ACT_RESV_UNREG;
                if ($urandom_range(0, 1) == 0)
                    id = ID_W'(RESV_SLOT + 1);
            end else if (pick < 97) begin
                act = ACT_READ_FLAG;
            end else begin
                act = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
            end
            send_item(act, ms, 1'($urandom), 1'($urandom), id);
        end
    endtask

    initial begin
        calm = 1'b0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.action = '0;
        in_ch.interval_ms = '0;
        in_ch.has_handler = 1'b0;
        in_ch.loop_mode = 1'b0;
        in_ch.slot_id = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_spare_and_empty();
        test_bank_full();
        test_bad_ids();
        test_flag_rearm();
        test_output_backpressure();
        test_random_traffic(400);
        calm = 1'b1;
        test_random_traffic(100);
        wait_results_drained();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
